### src/ssr_pkg.sv
// Shared constants and types for the SRRIP stream-bypass replacement block.
// No dependencies.
`default_nettype none
package ssr_pkg;
	localparam int NUM_SETS = 2048;
	localparam int NUM_WAYS = 16;
	localparam int SET_W = 11;
	localparam int WAY_W = 4;
	localparam int RRPV_W = 2;
	localparam logic [1:0] RRPV_MAX = 2'd3;
	localparam int DELTA_W = 32;
	localparam int ADDR_W = 64;
	localparam int CNT_W = 20;
	localparam int SIG_LSB = 5;
	localparam logic [1:0] REG_STREAM = 2'd0;
	localparam logic [1:0] REG_INSERT = 2'd1;
	localparam logic [1:0] REG_DECAY = 2'd2;
	localparam logic [4:0] PERIOD_MAX = 5'd20;

	// controller -> datapath commands
	typedef struct packed {
		logic capture;   // latch input request
		logic detect;    // latch set row and detector state from the memories
		logic commit;    // write back results
		logic decay;     // decrement all reuse counters
		logic clear;     // write reset values into one set row
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic is_victim;
		logic need_decay;
		logic clear_last;
	} sts_t;
endpackage
`default_nettype wire

### src/ssr_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ssr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### src/ssr_ctrl.sv
// Sequencer for the replacement block: clear, capture, read, detect, commit.
// Depends on ssr_pkg.
`default_nettype none
module ssr_ctrl import ssr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic out_busy,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      in_rdy,
	output logic      out_load
);
	typedef enum logic [2:0] {CLEAR, IDLE, READ, DETECT, COMMIT} state_t;
	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.capture = in_fire;
		cmd.detect = (state_q == DETECT);
		cmd.commit = (state_q == COMMIT) && !(sts.is_victim && out_busy);
		cmd.decay = cmd.commit && sts.need_decay;
		cmd.clear = (state_q == CLEAR);
		in_rdy = (state_q == IDLE);
		out_load = cmd.commit && sts.is_victim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
		end else begin
			case (state_q)
				CLEAR: if (sts.clear_last) state_q <= IDLE;
				IDLE: if (in_fire) state_q <= READ;
				READ: state_q <= DETECT;
				DETECT: state_q <= COMMIT;
				COMMIT: if (cmd.commit) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### src/ssr_dp.sv
// Datapath: set state memories, stream detector, victim search, reuse counters.
// Depends on ssr_pkg and ssr_ram.
`default_nettype none
module ssr_dp import ssr_pkg::*; #(
	parameter int HISTORY_LEN = 4,
	parameter int SIGNATURE_BITS = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output sts_t                    sts,
	input  wire logic               op,
	input  wire logic [SET_W-1:0]   set_index,
	input  wire logic [WAY_W-1:0]   way_index,
	input  wire logic [ADDR_W-1:0]  phys_addr,
	input  wire logic [ADDR_W-1:0]  prog_counter,
	input  wire logic               was_hit,
	input  wire logic [2:0]         stream_thr,
	input  wire logic [1:0]         insert_thr,
	input  wire logic [4:0]         decay_log2,
	output logic [WAY_W-1:0]        victim
);
	localparam int SA_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int HP_W = $clog2(HISTORY_LEN);
	localparam int SIG_N = 1 << SIGNATURE_BITS;
	localparam int ROW_W = NUM_WAYS * RRPV_W;
	localparam int HIST_W = HISTORY_LEN * DELTA_W;
	localparam int META_W = ADDR_W + HIST_W + HP_W + 1;

	// Request register
	logic op_q, hit_q, valid_q;
	logic [SA_W-1:0] set_q;
	logic [WAY_W-1:0] way_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIGNATURE_BITS-1:0] sig_q;

	// Clearing pass after reset walks every set row once.
	logic [SA_W-1:0] clr_q;
	logic [ROW_W-1:0] row_rd, row_q, row_wr, row_wdata;
	logic [META_W-1:0] meta_rd, meta_wr, meta_wdata;
	logic [ADDR_W-1:0] last_q;
	logic [HIST_W-1:0] hist_q;
	logic [HP_W-1:0] ptr_q;
	logic flag_q, flag_new;
	logic [1:0] ctr_q [SIG_N];
	logic [1:0] ctr_nx [SIG_N];
	logic [CNT_W-1:0] count_q;

	wire logic in_range = ({{(32-SET_W){1'b0}}, set_index} < 32'(NUM_SETS)) &&
		(op == 1'b0 || {{(32-WAY_W){1'b0}}, way_index} < 32'(NUM_WAYS));
	wire logic commit_we = cmd.commit && valid_q;
	wire logic we = commit_we || cmd.clear;
	wire logic [SA_W-1:0] wr_addr = cmd.clear ? clr_q : set_q;
	assign row_wdata = cmd.clear ? {NUM_WAYS{RRPV_MAX}} : row_wr;
	assign meta_wdata = cmd.clear ? '0 : meta_wr;

	ssr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rrpv (
		.clk(clk), .we(we), .waddr(wr_addr), .wdata(row_wdata),
		.raddr(set_q), .rdata(row_rd));
	ssr_ram #(.WIDTH(META_W), .DEPTH(NUM_SETS)) u_meta (
		.clk(clk), .we(we), .waddr(wr_addr), .wdata(meta_wdata),
		.raddr(set_q), .rdata(meta_rd));

	// Detector on the stored row
	logic [DELTA_W-1:0] delta;
	logic [HIST_W-1:0] hist_new;
	logic [3:0] hit_cnt;
	always_comb begin
		delta = DELTA_W'(addr_q - last_q);
		hist_new = hist_q;
		hist_new[ptr_q*DELTA_W +: DELTA_W] = delta;
		hit_cnt = '0;
		for (int i = 0; i < HISTORY_LEN; i++) begin
			hit_cnt = hit_cnt + 4'(hist_new[i*DELTA_W +: DELTA_W] == delta);
		end
		// keep the old flag when no previous address was recorded
		flag_new = (last_q == '0) ? flag_q : ({1'b0, hit_cnt} >= {2'b0, stream_thr});
	end

	// Victim search and aging
	logic [1:0] top;
	logic [WAY_W-1:0] best;
	always_comb begin
		top = '0;
		best = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (row_q[w*RRPV_W +: RRPV_W] > top) begin
				top = row_q[w*RRPV_W +: RRPV_W];
				best = WAY_W'(w);
			end
		end
	end

	logic [1:0] ctr_sig, cell_val;
	logic [4:0] period;
	logic [CNT_W-1:0] count_inc, pmask;
	logic [HP_W-1:0] ptr_nx;
	always_comb begin
		ctr_sig = ctr_q[sig_q];
		period = (decay_log2 == 5'd0) ? 5'd1 : (decay_log2 > PERIOD_MAX) ? PERIOD_MAX : decay_log2;
		pmask = CNT_W'((21'd1 << period) - 21'd1);
		count_inc = count_q + 1'b1;
		if (flag_new) cell_val = RRPV_MAX;
		else if (hit_q) cell_val = 2'd0;
		else cell_val = (ctr_sig >= insert_thr) ? 2'd0 : RRPV_MAX;
		row_wr = row_q;
		if (op_q == 1'b0) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				row_wr[w*RRPV_W +: RRPV_W] = row_q[w*RRPV_W +: RRPV_W] + (RRPV_MAX - top);
			end
		end else begin
			row_wr[way_q*RRPV_W +: RRPV_W] = cell_val;
		end
		ptr_nx = (HP_W'(ptr_q) == HP_W'(HISTORY_LEN - 1)) ? '0 : ptr_q + 1'b1;
		if (last_q != '0) meta_wr = {addr_q, hist_new, ptr_nx, flag_new};
		else meta_wr = {addr_q, hist_q, ptr_q, flag_new};
		sts.is_victim = (op_q == 1'b0);
		sts.need_decay = valid_q && op_q && !flag_new && ((count_inc & pmask) == '0);
		sts.clear_last = (clr_q == SA_W'(NUM_SETS - 1));
	end

	// Reuse counters: bump on a counted hit, then apply a pending decay
	logic upd_cnt;
	always_comb begin
		upd_cnt = commit_we && op_q && !flag_new;
		for (int i = 0; i < SIG_N; i++) begin
			ctr_nx[i] = ctr_q[i];
			if (upd_cnt && hit_q && SIGNATURE_BITS'(i) == sig_q && ctr_q[i] != 2'd3) begin
				ctr_nx[i] = ctr_q[i] + 2'd1;
			end
			if (cmd.decay && ctr_nx[i] != 2'd0) ctr_nx[i] = ctr_nx[i] - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= op;
			hit_q <= was_hit;
			set_q <= set_index[SA_W-1:0];
			way_q <= way_index;
			addr_q <= phys_addr;
			sig_q <= prog_counter[SIG_LSB +: SIGNATURE_BITS];
		end
		if (cmd.detect) begin
			row_q <= row_rd;
			{last_q, hist_q, ptr_q, flag_q} <= meta_rd;
		end
		if (cmd.commit && op_q == 1'b0) victim <= valid_q ? best : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			clr_q <= '0;
			count_q <= '0;
			for (int i = 0; i < SIG_N; i++) ctr_q[i] <= 2'd1;
		end else begin
			if (cmd.capture) valid_q <= in_range;
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (upd_cnt) count_q <= count_inc;
			for (int i = 0; i < SIG_N; i++) ctr_q[i] <= ctr_nx[i];
		end
	end
endmodule
`default_nettype wire

### src/ship_srrip_stream_bypass_replacement.sv
// Top level of the SRRIP replacement block with stream bypass.
// Depends on ssr_pkg, ssr_ctrl, ssr_dp.
//
// Usage: requests enter on the s_axis channel (op, set, way, address, PC, hit).
// A find-victim request (op 0) yields one result on m_axis with the chosen way;
// an update request (op 1) yields none. The user must write config registers over
// APB only while the block is idle; the block does not enforce it. paddr[3:2]
// selects 0 stream threshold, 1 insert threshold, 2 decay log2. A request goes
// through capture, registered set-row memory read, detect/search and commit. A
// result appears on m_axis the cycle after commit and waits in the output register;
// while it is not taken the next victim request stalls at commit, updates still
// proceed. Reset initializes control, counters and config, then a clearing pass
// over all NUM_SETS (2048) set rows writes each back to RRPV 3 with an empty
// detector; s_axis_tready stays low until that pass ends.
`default_nettype none
module ship_srrip_stream_bypass_replacement import ssr_pkg::*; #(
	parameter int HISTORY_LEN = 4,
	parameter int SIGNATURE_BITS = 5
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// tdata: op[0], set_index[11:1], way_index[15:12], phys_addr[79:16],
	// prog_counter[143:80], was_hit[144], zero fill to 152
	input  wire logic [151:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// tdata: victim_way[3:0], zero fill
	output logic [7:0]        m_axis_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	cmd_t cmd;
	sts_t sts;
	logic in_rdy, out_load;
	logic [3:0] victim;
	logic [2:0] stream_thr_q;
	logic [1:0] insert_thr_q;
	logic [4:0] decay_q;
	wire logic in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = in_rdy;
	assign pready = 1'b1;

	// Hold register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_thr_q <= 3'd3;
			insert_thr_q <= 2'd2;
			decay_q <= 5'd12;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_STREAM: stream_thr_q <= pwdata[2:0];
				REG_INSERT: insert_thr_q <= pwdata[1:0];
				REG_DECAY: decay_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_STREAM: prdata = {29'd0, stream_thr_q};
			REG_INSERT: prdata = {30'd0, insert_thr_q};
			REG_DECAY: prdata = {27'd0, decay_q};
			default: prdata = '0;
		endcase
	end

	// Output register: load on victim commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end
	assign m_axis_tdata = {4'd0, victim};

	ssr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(m_axis_tvalid && !m_axis_tready), .sts(sts), .cmd(cmd),
		.in_rdy(in_rdy), .out_load(out_load));

	ssr_dp #(
		.HISTORY_LEN(HISTORY_LEN), .SIGNATURE_BITS(SIGNATURE_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.op(s_axis_tdata[0]), .set_index(s_axis_tdata[11:1]),
		.way_index(s_axis_tdata[15:12]), .phys_addr(s_axis_tdata[79:16]),
		.prog_counter(s_axis_tdata[143:80]), .was_hit(s_axis_tdata[144]),
		.stream_thr(stream_thr_q), .insert_thr(insert_thr_q), .decay_log2(decay_q),
		.victim(victim));
endmodule
`default_nettype wire
